>>> hdl/mf3_pkg.sv
// Shared widths, register indexes, pipeline types and sort helpers for the 3x3 median filter.
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 11;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);
  localparam logic [CFG_W-1:0] MIN_SIZE         = CFG_W'(3);

  typedef struct packed {
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] lo;
  } col_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic valid;
    logic emit;
    tag_t tag;
  } pipe_t;

  function automatic col_t sort3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                 input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] x0, x1, y0, y1, z0, z1;
    col_t r;
    x0 = (a < b) ? a : b;
    x1 = (a < b) ? b : a;
    y0 = (x1 < c) ? x1 : c;
    y1 = (x1 < c) ? c : x1;
    z0 = (x0 < y0) ? x0 : y0;
    z1 = (x0 < y0) ? y0 : x0;
    r.lo = z0;
    r.md = z1;
    r.hi = y1;
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] lo, hi, t;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    t  = (hi < c) ? hi : c;
    return (lo > t) ? lo : t;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mf3_if.sv
// Stream and configuration channel interfaces of the 3x3 median filter.
`timescale 1ns / 1ps
`default_nettype none

interface mf3_pix_if import mf3_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface mf3_res_if import mf3_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   median_value;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  modport source (output valid, output median_value, output out_row, output out_col,
                  input ready);
  modport sink   (input valid, input median_value, input out_row, input out_col,
                  output ready);
endinterface

interface mf3_cfg_if import mf3_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/mf3_line_mem.sv
// Combined two-row line store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mf3_line_mem import mf3_pkg::*; #(
  parameter int DEPTH  = MAX_WIDTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_W-1:0]    waddr,
  input  wire logic [2*PIX_W-1:0]   wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_W-1:0]    raddr,
  output      logic [2*PIX_W-1:0]   rdata
);

  logic [2*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/mf3_window.sv
// Column sort and 3-column window of sorted columns.
`timescale 1ns / 1ps
`default_nettype none

module mf3_window import mf3_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire pipe_t            s_in,
  input  wire logic [PIX_W-1:0] top,
  input  wire logic [PIX_W-1:0] mid,
  input  wire logic [PIX_W-1:0] bot,
  output      pipe_t            s_out,
  output      col_t             c0,
  output      col_t             c1,
  output      col_t             c2
);

  col_t win1, win2, cur;

  assign cur = sort3(top, mid, bot);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_out <= '0;
      win1  <= '0;
      win2  <= '0;
    end else if (en) begin
      s_out <= s_in;
      if (s_in.valid) begin
        win1 <= cur;
        win2 <= win1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0 <= cur;
      c1 <= win1;
      c2 <= win2;
    end
  end

endmodule

`default_nettype wire

>>> hdl/mf3_median.sv
// Median of three sorted columns: row reduction stage, then median of three.
`timescale 1ns / 1ps
`default_nettype none

module mf3_median import mf3_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire pipe_t            s_in,
  input  wire col_t             c0,
  input  wire col_t             c1,
  input  wire col_t             c2,
  output      pipe_t            s_out,
  output      logic [PIX_W-1:0] median
);

  logic [PIX_W-1:0] lo_max, md_med, hi_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_out <= '0;
    end else if (en) begin
      s_out <= s_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_max <= max3(c0.lo, c1.lo, c2.lo);
      md_med <= med3(c0.md, c1.md, c2.md);
      hi_min <= min3(c0.hi, c1.hi, c2.hi);
    end
  end

  assign median = med3(lo_max, md_med, hi_min);

endmodule

`default_nettype wire

>>> hdl/median_filter_3x3_top.sv
// Top level of the streaming 3x3 median filter.
// A result passes s1, the window stage, the median stage and the output register.
// One pixel per clock unless the output stalls; one line store read and write per cycle.
// pix_in.ready is high while the output register is empty or being taken.
// Reset clears counters, pipeline valids and window, and sets the frame to 640 x 480.
// Line stores are not cleared; they are filled by the first two rows of a frame.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3_top import mf3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  mf3_pix_if.sink   pix_in,
  mf3_res_if.source res_out,
  mf3_cfg_if.sink   cfg
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int SZ_W   = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int CW     = (ADDR_W > COORD_W) ? ADDR_W : COORD_W;
  localparam logic [SZ_W-1:0] W_MAX = SZ_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] H_MAX = CFG_W'(MAX_HEIGHT);

  logic [CFG_W-1:0]   frame_width, frame_height;
  logic [SZ_W-1:0]    w_eff, w_last;
  logic [CFG_W-1:0]   h_eff, h_tmp;
  logic [COORD_W-1:0] h_last;
  logic [ADDR_W-1:0]  col_count, col_count_next, addr1;
  logic [COORD_W-1:0] row_count, row_count_next;
  logic [CW-1:0]      col_m1;
  logic               adv, accept, col_wrap;
  logic [PIX_W-1:0]   p1;
  logic [2*PIX_W-1:0] rdata;
  pipe_t              s1, s1_next, s2, s3;
  col_t               c0, c1, c2;
  logic [PIX_W-1:0]   median;
  logic               o_valid;
  logic [PIX_W-1:0]   o_median;
  tag_t               o_tag;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < MIN_SIZE) begin
      w_eff = SZ_W'(MIN_SIZE);
    end else if (SZ_W'(frame_width) > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = SZ_W'(frame_width);
    end
    w_last = w_eff - SZ_W'(1);
    if (frame_height < MIN_SIZE) begin
      h_eff = MIN_SIZE;
    end else if (frame_height > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = frame_height;
    end
    h_tmp  = h_eff - CFG_W'(1);
    h_last = h_tmp[COORD_W-1:0];
  end

  // input stage and position counters
  assign adv          = !o_valid || res_out.ready;
  assign pix_in.ready = adv;
  assign accept       = pix_in.valid && adv;

  assign col_wrap = SZ_W'(col_count) >= w_last;
  assign col_m1   = CW'(col_count) - CW'(1);

  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    if (accept) begin
      if (col_wrap) begin
        col_count_next = '0;
        row_count_next = (row_count >= h_last) ? '0 : row_count + COORD_W'(1);
      end else begin
        col_count_next = col_count + ADDR_W'(1);
      end
    end
    s1_next.valid   = accept;
    s1_next.emit    = (row_count >= COORD_W'(2)) && (col_count >= ADDR_W'(2));
    s1_next.tag.row = row_count - COORD_W'(1);
    s1_next.tag.col = col_m1[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1        <= '0;
    end else begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      if (adv) begin
        s1 <= s1_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1    <= pix_in.pixel;
      addr1 <= col_count;
    end
  end

  // line store: high byte is the row two above, low byte the row above
  mf3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .ADDR_W(ADDR_W)
  ) u_line_mem (
    .clk  (clk),
    .we   (adv && s1.valid),
    .waddr(addr1),
    .wdata({rdata[PIX_W-1:0], p1}),
    .re   (accept),
    .raddr(col_count),
    .rdata(rdata)
  );

  mf3_window u_window (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .s_in (s1),
    .top  (rdata[2*PIX_W-1:PIX_W]),
    .mid  (rdata[PIX_W-1:0]),
    .bot  (p1),
    .s_out(s2),
    .c0   (c0),
    .c1   (c1),
    .c2   (c2)
  );

  mf3_median u_median (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .s_in  (s2),
    .c0    (c0),
    .c1    (c1),
    .c2    (c2),
    .s_out (s3),
    .median(median)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= s3.valid && s3.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_median <= median;
      o_tag    <= s3.tag;
    end
  end

  assign res_out.valid        = o_valid;
  assign res_out.median_value = o_median;
  assign res_out.out_row      = o_tag.row;
  assign res_out.out_col      = o_tag.col;

  // checks
  a_no_same_addr: assert property (@(posedge clk) disable iff (rst)
    (adv && s1.valid && accept) |-> (addr1 != col_count))
    else $error("line store read and write hit the same entry");

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> (res_out.out_row != '0) && (res_out.out_col != '0))
    else $error("border position emitted");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && col_wrap) |=> (col_count == '0))
    else $error("column counter failed to wrap");

  a_emit_pipe: assert property (@(posedge clk) disable iff (rst)
    (adv && !s3.valid) |=> !o_valid)
    else $error("result without a pixel behind it");

endmodule

`default_nettype wire

>>> bench/median_filter_3x3_top_tb.sv
// Self-checking testbench for median_filter_3x3_top: window predictor, random gaps and stalls.
`timescale 1ns / 1ps

module median_filter_3x3_top_tb;
  import mf3_pkg::*;

  localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
  localparam int SETTLE_CYC    = 8;
  localparam int QUIET_LIMIT   = 400;
  localparam int MAX_GAP       = 10;
  localparam int RANDOM_BEATS  = 1350;
  localparam int MAX_ERR_LINES = 40;
  localparam int FILL_COLS     = 192;
  localparam int NARROW_MAX    = 80;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PIX_W-1:0]   median_value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
  } median_t;

  typedef enum int {PX_ANY, PX_NEAR, PX_RAIL} px_style_t;

  logic clk;
  logic rst;

  mf3_pix_if pix_if ();
  mf3_res_if res_if ();
  mf3_cfg_if cfg_if ();

  median_filter_3x3_top uut (
    .clk(clk),
    .rst(rst),
    .pix_in(pix_if),
    .res_out(res_if),
    .cfg(cfg_if)
  );

  // shadow of the filter state
  logic [PIX_W-1:0] upper_line [LINE_DEPTH];
  logic [PIX_W-1:0] lower_line [LINE_DEPTH];
  logic [PIX_W-1:0] win [6];
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  median_t          median_q [$];
  logic [PIX_W-1:0] pixel_q [$];

  int err_count;
  int quiet_cycles;
  int gap_left;
  int stall_left;
  bit pix_fire;
  bit res_fire;
  bit cfg_fire;
  bit pix_steady;
  bit res_steady;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIZE) return 32'(MIN_SIZE);
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // fifth smallest of nine
  function automatic logic [PIX_W-1:0] median_of_nine(input logic [9*PIX_W-1:0] px);
    int lower;
    int same;
    for (int i = 0; i < 9; i++) begin
      lower = 0;
      same  = 0;
      for (int j = 0; j < 9; j++) begin
        if (px[j*PIX_W +: PIX_W] < px[i*PIX_W +: PIX_W]) lower++;
        else if (px[j*PIX_W +: PIX_W] == px[i*PIX_W +: PIX_W]) same++;
      end
      if (lower <= 4 && lower + same > 4) return px[i*PIX_W +: PIX_W];
    end
    return '0;
  endfunction

  function automatic int draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return CFG_W'($urandom_range(0, 2));
      1: return CFG_W'($urandom_range(2048, 4095));
      2: return CFG_W'($urandom_range(13, 80));
      default: return CFG_W'($urandom_range(3, 12));
    endcase
  endfunction

  task automatic report(input string what);
    err_count++;
    if (err_count <= MAX_ERR_LINES) $display("ERROR %0t ns: %s", $time, what);
  endtask

  task automatic filter_pixel(input logic [PIX_W-1:0] bot);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    median_t          e;
    w   = eff_size(width_reg, MAX_WIDTH_DEF);
    h   = eff_size(height_reg, MAX_HEIGHT);
    c   = col_pos % LINE_DEPTH;
    top = upper_line[c];
    mid = lower_line[c];
    if (row_pos >= 2 && col_pos >= 2) begin
      e.median_value = median_of_nine({win[3], win[4], win[5], win[0], win[1], win[2],
                                       top, mid, bot});
      e.out_row = COORD_W'(row_pos - 1);
      e.out_col = COORD_W'(col_pos - 1);
      median_q.push_back(e);
    end
    upper_line[c] = mid;
    lower_line[c] = bot;
    for (int k = 3; k < 6; k++) win[k] = win[k-3];
    win[0] = top;
    win[1] = mid;
    win[2] = bot;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic push_frame9(input logic [9*PIX_W-1:0] px);
    for (int i = 8; i >= 0; i--) pixel_q.push_back(px[i*PIX_W +: PIX_W]);
  endtask

  task automatic push_random(input int unsigned n, input px_style_t style,
                             input logic [PIX_W-1:0] base);
    for (int unsigned i = 0; i < n; i++) begin
      case (style)
        PX_NEAR: pixel_q.push_back(base + PIX_W'($urandom_range(0, 3)));
        PX_RAIL: pixel_q.push_back($urandom_range(0, 1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}});
        default: pixel_q.push_back(PIX_W'($urandom));
      endcase
    end
  endtask

  task automatic settle();
    @(posedge clk);
    while (pixel_q.size() != 0 || pix_if.valid || median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // pixel driver
  always @(negedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
      gap_left = 0;
    end else if (pix_fire || !pix_if.valid) begin
      if (gap_left > 0) begin
        gap_left--;
        pix_if.valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        pix_if.valid <= 1'b1;
        pix_if.pixel <= pixel_q.pop_front();
        if ($urandom_range(0, 47) == 0) pix_steady = !pix_steady;
        gap_left = draw_wait(pix_steady);
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_fire) begin
        if ($urandom_range(0, 47) == 0) res_steady = !res_steady;
        stall_left = draw_wait(res_steady);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // monitor: compare, predict, watchdog
  always @(posedge clk) begin
    median_t want;
    pix_fire = !rst && pix_if.valid && pix_if.ready;
    res_fire = !rst && res_if.valid && res_if.ready;
    cfg_fire = !rst && cfg_if.valid && cfg_if.ready;
    if (res_fire) begin
      if (median_q.size() == 0) begin
        report($sformatf("unexpected beat: median %0d at (%0d,%0d)",
                         res_if.median_value, res_if.out_row, res_if.out_col));
      end else begin
        want = median_q.pop_front();
        if (res_if.median_value !== want.median_value)
          report($sformatf("median %0d, expected %0d at (%0d,%0d)", res_if.median_value,
                           want.median_value, want.out_row, want.out_col));
        if (res_if.out_row !== want.out_row)
          report($sformatf("out_row %0d, expected %0d", res_if.out_row, want.out_row));
        if (res_if.out_col !== want.out_col)
          report($sformatf("out_col %0d, expected %0d", res_if.out_col, want.out_col));
      end
    end
    if (cfg_fire) begin
      if (cfg_if.index == REG_FRAME_WIDTH) width_reg = cfg_if.data;
      else if (cfg_if.index == REG_FRAME_HEIGHT) height_reg = cfg_if.data;
    end
    if (pix_fire) filter_pixel(pix_if.pixel);
    if (rst || pix_fire || res_fire || cfg_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: %0d cycles without a beat", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned      sent;
    int unsigned      chunk;
    px_style_t        style;
    logic [PIX_W-1:0] base;
    rst = 1'b1;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FRAME_WIDTH;
    cfg_if.data  = '0;
    err_count    = 0;
    quiet_cycles = 0;
    pix_fire     = 1'b0;
    res_fire     = 1'b0;
    cfg_fire     = 1'b0;
    pix_steady   = 1'b0;
    res_steady   = 1'b0;
    row_pos      = 0;
    col_pos      = 0;
    width_reg    = FRAME_WIDTH_RST;
    height_reg   = FRAME_HEIGHT_RST;
    for (int k = 0; k < 6; k++) win[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // start of row 0 at reset size, no output yet
    pixel_q.push_back(8'h00);
    pixel_q.push_back(8'hFF);
    pixel_q.push_back(8'h0F);
    pixel_q.push_back(8'hF0);
    settle();

    // out-of-range sizes clamp to 3x3; column counter already past the new width
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd2);
    write_reg(REG_SPARE_LO, 12'hFFF);
    write_reg(REG_SPARE_HI, 12'h001);
    pixel_q.push_back(8'h80);
    pixel_q.push_back(8'h01);
    pixel_q.push_back(8'h7F);
    pixel_q.push_back(8'hFE);
    pixel_q.push_back(8'h40);
    pixel_q.push_back(8'h20);
    pixel_q.push_back(8'h10);
    push_frame9(72'hFF00FF_00FF00_FF00FF);
    push_frame9(72'h908070_605040_302010);
    settle();

    // tall frame; fills the line store past any column reached below
    write_reg(REG_FRAME_WIDTH, CFG_W'(FILL_COLS));
    write_reg(REG_FRAME_HEIGHT, 12'd2048);
    push_random(2 * FILL_COLS + 60, PX_ANY, '0);
    settle();

    // shrink mid-frame, then leave both counters past the next size
    write_reg(REG_FRAME_WIDTH, 12'd6);
    write_reg(REG_FRAME_HEIGHT, 12'd8);
    push_random(18, PX_ANY, '0);
    settle();
    write_reg(REG_FRAME_HEIGHT, 12'd4);
    write_reg(REG_FRAME_WIDTH, 12'd4);

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      chunk = $urandom_range(15, 90);
      style = px_style_t'($urandom_range(0, 2));
      base  = PIX_W'($urandom);
      push_random(chunk, style, base);
      sent += chunk;
      settle();
      // a wide line lasts one chunk so columns stay inside the filled part
      if (eff_size(width_reg, MAX_WIDTH_DEF) > NARROW_MAX) begin
        write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(MIN_SIZE, NARROW_MAX)));
      end else begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_FRAME_WIDTH, pick_size());
          1: write_reg(REG_FRAME_HEIGHT, pick_size());
          2: begin
            write_reg(REG_FRAME_WIDTH, pick_size());
            write_reg(REG_FRAME_HEIGHT, pick_size());
          end
          default: write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                             CFG_W'($urandom));
        endcase
      end
    end
    settle();

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
